>>> rtl/compacting_slot_list_top_defines.svh
// Assertion macros for the compacting slot list.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef COMPACTING_SLOT_LIST_TOP_DEFINES_SVH
`define COMPACTING_SLOT_LIST_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge.
`define CSL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot list check failed: same-cycle implication");
// Next-cycle implication, sampled on the rising clock edge.
`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot list check failed: next-cycle implication");
`else
`define CSL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/csl_pkg.sv
`default_nettype none
package csl_pkg;

  // Slot row geometry
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int ID_W   = 31;
  localparam int SEL_W  = 4;
  localparam int STAT_W = 3;
  localparam int OIDX_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_PRESENT  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_BADCMD   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_READ,
    ST_FINISH
  } state_t;

  // Slot address to the reported index, taken modulo 16
  function automatic logic [OIDX_W-1:0] idx_to_out(input logic [SLOT_AW-1:0] idx);
    logic [SLOT_AW+OIDX_W-1:0] wide;
    wide = {{OIDX_W{1'b0}}, idx};
    return wide[OIDX_W-1:0];
  endfunction

  // Slot select to a slot address (only meaningful when in range)
  function automatic logic [SLOT_AW-1:0] sel_to_addr(input logic [SEL_W-1:0] sel);
    logic [SLOT_AW+SEL_W-1:0] wide;
    wide = {{SLOT_AW{1'b0}}, sel};
    return wide[SLOT_AW-1:0];
  endfunction

  // Slot select names an existing slot
  function automatic logic sel_fits(input logic [SEL_W-1:0] sel);
    return (32'(sel) < SLOT_COUNT);
  endfunction

endpackage
`default_nettype wire

>>> rtl/csl_if.sv
`default_nettype none
// Request channel: command, identifier and slot select
interface csl_in_if;
  import csl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   item_id;
  logic [SEL_W-1:0]  slot_select;

  modport source (output valid, output command, output item_id, output slot_select,
                  input ready);
  modport sink   (input valid, input command, input item_id, input slot_select,
                  output ready);
endinterface

// Result channel: status, slot index and slot value
interface csl_out_if;
  import csl_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OIDX_W-1:0] slot_index;
  logic [ID_W-1:0]   slot_value;

  modport source (output valid, output status, output slot_index, output slot_value,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input slot_value,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/compacting_slot_list_top.sv
// Path from input transfer to result valid: add scans from slot 0 until a match or an
// empty slot, or through the last slot on a full list; delete scans to the match, then
// alternates ST_SHIFT and ST_SHIFT_WR for each entry moved down; read passes ST_READ,
// bad command goes straight to ST_FINISH; a stalled result register adds its wait.
// Throughput: one command at a time, one slot per cycle while scanning over the single
// read port of the slot RAM; a new command is taken while one result waits.
// Reset: synchronous, active low; occupancy flags clear at once, the list reads empty.
`default_nettype none
`include "compacting_slot_list_top_defines.svh"
module compacting_slot_list_top (
  input wire logic  clk,
  input wire logic  rst_n,
  csl_in_if.sink    in_ch,
  csl_out_if.source out_ch
);
  import csl_pkg::*;

  state_t                 state_r, state_nxt;
  logic [SLOT_AW-1:0]     idx_r, idx_nxt;
  logic [SLOT_AW-1:0]     idx_inc;
  logic [SLOT_COUNT-1:0]  occ_r, occ_nxt;
  logic [CMD_W-1:0]       cmd_r;
  logic [ID_W-1:0]        id_r;
  logic [SEL_W-1:0]       sel_r;

  status_t                res_status_r, res_status_nxt;
  logic [OIDX_W-1:0]      res_index_r, res_index_nxt;
  logic [ID_W-1:0]        res_value_r, res_value_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r;
  logic [OIDX_W-1:0]      out_index_r;
  logic [ID_W-1:0]        out_value_r;
  logic                   load_out;

  logic                   in_xfer;
  logic                   ram_we;
  logic [SLOT_AW-1:0]     ram_waddr;
  logic [ID_W-1:0]        ram_wdata;
  logic [SLOT_AW-1:0]     ram_raddr;
  logic [ID_W-1:0]        ram_rdata;

  logic                   last_slot;
  logic [ID_W-1:0]        slot_val;
  logic                   slot_match;
  logic                   slot_empty;

  // Slot storage
  csl_ram #(
    .WIDTH (ID_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and shared compare
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign idx_inc     = idx_r + SLOT_AW'(1);
  assign last_slot   = (idx_r == SLOT_AW'(SLOT_COUNT - 1));
  assign slot_val    = occ_r[idx_r] ? ram_rdata : '0;
  assign slot_match  = (slot_val == id_r);
  assign slot_empty  = !occ_r[idx_r];

  // Sequencer: next state, RAM control, result
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    occ_nxt        = occ_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_value_nxt  = res_value_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = idx_inc;
    load_out       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = (in_ch.command == CMD_READ) ? sel_to_addr(in_ch.slot_select) : '0;
        if (in_ch.valid) begin
          idx_nxt = '0;
          unique case (in_ch.command)
            CMD_ADD, CMD_DELETE: state_nxt = ST_SCAN;
            CMD_READ:            state_nxt = ST_READ;
            default: begin
              res_status_nxt = STAT_BADCMD;
              res_index_nxt  = '0;
              res_value_nxt  = '0;
              state_nxt      = ST_FINISH;
            end
          endcase
        end
      end

      // Compare one slot per cycle while the next one is read
      ST_SCAN: begin
        res_value_nxt = '0;
        priority if (slot_match) begin
          res_index_nxt = idx_to_out(idx_r);
          if (cmd_r == CMD_ADD) begin
            res_status_nxt = STAT_PRESENT;
            state_nxt      = ST_FINISH;
          end else begin
            res_status_nxt = STAT_OK;
            state_nxt      = ST_SHIFT;
          end
        end else if (slot_empty && (cmd_r == CMD_ADD)) begin
          ram_we         = 1'b1;
          ram_wdata      = id_r;
          occ_nxt[idx_r] = 1'b1;
          res_status_nxt = STAT_OK;
          res_index_nxt  = idx_to_out(idx_r);
          state_nxt      = ST_FINISH;
        end else if (last_slot) begin
          res_status_nxt = (cmd_r == CMD_ADD) ? STAT_FULL : STAT_NOTFOUND;
          res_index_nxt  = '0;
          state_nxt      = ST_FINISH;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      // Move later entries down until an empty slot or the end
      ST_SHIFT: begin
        priority if (last_slot) begin
          occ_nxt[idx_r] = 1'b0;
          state_nxt      = ST_FINISH;
        end else if (slot_empty) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SHIFT_WR;
        end
      end

      ST_SHIFT_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata;
        occ_nxt[idx_r] = occ_r[idx_inc];
        idx_nxt        = idx_inc;
        state_nxt      = ST_SHIFT;
      end

      ST_READ: begin
        res_index_nxt = sel_r;
        if (sel_fits(sel_r)) begin
          res_status_nxt = STAT_OK;
          res_value_nxt  = occ_r[sel_to_addr(sel_r)] ? ram_rdata : '0;
        end else begin
          res_status_nxt = STAT_NOTFOUND;
          res_value_nxt  = '0;
        end
        state_nxt = ST_FINISH;
      end

      // Hand the result to the output register once it is free
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_value_r  <= res_value_nxt;
    if (in_xfer) begin
      cmd_r <= in_ch.command;
      id_r  <= in_ch.item_id;
      sel_r <= in_ch.slot_select;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_value_r  <= res_value_r;
    end
  end

  // Drive the result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_index = out_index_r;
  assign out_ch.slot_value = out_value_r;

  // Checks
  `CSL_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, !in_ch.ready)
  `CSL_ASSERT_IMPL(a_occ_packed, clk, rst_n, 1'b1, ((occ_r & (occ_r + SLOT_COUNT'(1))) == '0))
  `CSL_ASSERT_IMPL(a_out_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_FINISH))

endmodule
`default_nettype wire

>>> rtl/csl_ram.sv
`default_nettype none
// Simple dual-port RAM: one write port, one registered read port
module csl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> tb/compacting_slot_list_top_tb.sv
module compacting_slot_list_top_tb;
  import csl_pkg::*;

  // Command code that the block must reject
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [ID_W-1:0]  ID_MAX     = '1;
  localparam int               CYCLE_LIMIT = 400_000;
  localparam int               DRAIN_CYCLES = 64;
  localparam int               HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    status_t           status;
    logic [OIDX_W-1:0] slot_index;
    logic [ID_W-1:0]   slot_value;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst_n;

  // Pacing controls: sender gaps, receiver stalls, long receiver hold-off
  bit   tx_gaps_on = 1'b1;
  logic rx_gaps_on = 1'b1;
  logic rx_hold = 1'b0;

  int mismatch_count = 0;

  // Mirror of the slot row and the results still owed by the block
  logic [ID_W-1:0] slot_row [SLOT_COUNT];
  slot_result_t    pending_results [$];

  csl_in_if  in_ch();
  csl_out_if out_ch();

  compacting_slot_list_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the mirror and return the result it must produce
  function automatic slot_result_t apply_request(input logic [CMD_W-1:0] cmd,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [SEL_W-1:0] sel);
    slot_result_t r;
    int i;
    int k;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        r.status = STAT_FULL;
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (slot_row[i] == id) begin
            r.status = STAT_PRESENT;
            r.slot_index = OIDX_W'(i);
            break;
          end
          if (slot_row[i] == '0) begin
            slot_row[i] = id;
            r.status = STAT_OK;
            r.slot_index = OIDX_W'(i);
            break;
          end
        end
      end
      CMD_DELETE: begin
        r.status = STAT_NOTFOUND;
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (slot_row[i] == id) begin
            // shift later entries down until an empty slot or the end
            for (k = i; k < SLOT_COUNT; k++) begin
              if (k == SLOT_COUNT - 1) begin
                slot_row[k] = '0;
                break;
              end
              if (slot_row[k] == '0) break;
              slot_row[k] = slot_row[k + 1];
            end
            r.status = STAT_OK;
            r.slot_index = OIDX_W'(i);
            break;
          end
        end
      end
      CMD_READ: begin
        r.slot_index = OIDX_W'(sel);
        if (32'(sel) < SLOT_COUNT) begin
          r.status = STAT_OK;
          r.slot_value = slot_row[sel];
        end else begin
          r.status = STAT_NOTFOUND;
        end
      end
      default: begin
        r.status = STAT_BADCMD;
      end
    endcase
    return r;
  endfunction

  // Offer one command, wait for its transfer, then record the expected result
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [SEL_W-1:0] sel);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.item_id     <= id;
    in_ch.slot_select <= sel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), apply_request(cmd, id, sel));
  endtask

  // Mostly identifiers from a small pool so adds and deletes collide and the
  // row fills; the rest are zero or arbitrary 31-bit values
  function automatic logic [ID_W-1:0] draw_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 20) return ID_W'($urandom());
    return ID_W'($urandom_range(1, 24));
  endfunction

  task automatic send_random_items(input int count, input int add_pct, input int del_pct);
    int n;
    int r;
    logic [CMD_W-1:0] cmd;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) cmd = CMD_ADD;
      else if (r < add_pct + del_pct) cmd = CMD_DELETE;
      else if (r < 96) cmd = CMD_READ;
      else cmd = CMD_UNUSED;
      send_request(cmd, draw_id(), SEL_W'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_empty_list();
    send_request(CMD_READ, '0, '0);
    send_request(CMD_ADD, '0, '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_DELETE, ID_MAX, '0);
    send_request(CMD_UNUSED, ID_MAX, '1);
  endtask

  task automatic test_full_list();
    int n;
    send_request(CMD_ADD, ID_MAX, '0);
    for (n = 1; n < SLOT_COUNT; n++) send_request(CMD_ADD, ID_W'(n), '0);
    send_request(CMD_ADD, ID_MAX, '0);
    send_request(CMD_ADD, ID_W'(SLOT_COUNT), '0);
    send_request(CMD_ADD, '0, '0);
    send_request(CMD_DELETE, '0, '0);
    // remove the front entry of a full row: every entry moves, last slot empties
    send_request(CMD_DELETE, ID_MAX, '0);
    send_request(CMD_ADD, ID_W'(SLOT_COUNT), '0);
    // match sits in the last slot
    send_request(CMD_DELETE, ID_W'(SLOT_COUNT), '0);
    send_request(CMD_READ, '0, 4'd14);
  endtask

  task automatic test_add_heavy_traffic();
    tx_gaps_on = 1'b1;
    rx_gaps_on <= 1'b1;
    send_random_items(250, 50, 20);
  endtask

  task automatic test_back_to_back();
    tx_gaps_on = 1'b0;
    rx_gaps_on <= 1'b0;
    send_random_items(150, 35, 35);
  endtask

  task automatic test_delete_heavy_traffic();
    tx_gaps_on = 1'b1;
    rx_gaps_on <= 1'b1;
    send_random_items(250, 20, 50);
  endtask

  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on <= 1'b1;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      send_random_items(60, 40, 30);
    join
  endtask

  // Accept results with random stalls and compare against the oldest expectation
  initial begin : result_sink
    int stall;
    slot_result_t want;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d index %0d value %0h",
                 out_ch.status, out_ch.slot_index, out_ch.slot_value);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            mismatch_count++;
          end
          if (out_ch.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d",
                   want.slot_index, out_ch.slot_index);
            mismatch_count++;
          end
          if (out_ch.slot_value !== want.slot_value) begin
            $error("slot_value: expected %0h, actual %0h",
                   want.slot_value, out_ch.slot_value);
            mismatch_count++;
          end
        end
        stall = rx_gaps_on ? $urandom_range(0, 12) : 0;
      end
      // hold ready low during reset, a long hold-off or a drawn stall
      if (!rst_n || rx_hold) begin
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int n;
    for (n = 0; n < SLOT_COUNT; n++) slot_row[n] = '0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_ADD;
    in_ch.item_id     <= '0;
    in_ch.slot_select <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_full_list();
    test_add_heavy_traffic();
    test_back_to_back();
    test_backpressure();
    test_delete_heavy_traffic();

    // drop valid and let the remaining results drain
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
